FILE: hdl/lsfb_pkg.sv
// Package for the LED strip frame builder.
// Holds request codes, frame constants and the sequencer state type; no dependencies.
`default_nettype none

package lsfb_pkg;

  localparam int LED_COUNT_DEF = 64;
  localparam int START_BYTES   = 4;
  localparam int END_DIVISOR   = 16;
  localparam logic [7:0] FULL_BRIGHT = 8'hFF;

  localparam logic [1:0] REQ_SET  = 2'd0;
  localparam logic [1:0] REQ_FILL = 2'd1;
  localparam logic [1:0] REQ_EMIT = 2'd2;

  localparam logic [1:0] LANE_BRIGHT = 2'd0;
  localparam logic [1:0] LANE_BLUE   = 2'd1;
  localparam logic [1:0] LANE_GREEN  = 2'd2;
  localparam logic [1:0] LANE_RED    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_FILL
  } lsfb_state_e;

endpackage

`default_nettype wire

FILE: hdl/led_strip_frame_builder_core.sv
// Top level of the LED strip frame builder: pixel store, fill sweep and frame byte sequencer.
// Depends on lsfb_pkg for request codes, frame constants and the state type.
//
//  Channel   Ports                                                   Direction
//  request   start_i, busy_o, req_type_i, pixel_index_i,             in
//            red_i, green_i, blue_i
//  result    result_valid_o, frame_byte_o, frame_end_o               out
//
// A set request writes the store at the accept edge. For an emit request the store
// is read at the accept edge and the word is presented in the following cycle.
// A fill request writes one store entry per cycle through the single write port.
// After reset the same sweep clears the store to zero, with busy_o held high
// until it ends. The receiver cannot stall.
`default_nettype none

module led_strip_frame_builder_core
  import lsfb_pkg::*;
#(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [1:0] req_type_i,
  input  wire logic [5:0] pixel_index_i,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  output logic            result_valid_o,
  output logic [7:0]      frame_byte_o,
  output logic            frame_end_o
);

  localparam int AW          = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int PIXEL_BYTES = 4 * LED_COUNT;
  localparam int END_BYTES   = (LED_COUNT + END_DIVISOR - 1) / END_DIVISOR;
  localparam int FRAME_BYTES = START_BYTES + PIXEL_BYTES + END_BYTES;
  localparam int PW          = $clog2(FRAME_BYTES);

  localparam logic [PW-1:0] POS_LAST      = PW'(FRAME_BYTES - 1);
  localparam logic [PW-1:0] POS_PIX_FIRST = PW'(START_BYTES);
  localparam logic [PW-1:0] POS_PIX_END   = PW'(START_BYTES + PIXEL_BYTES);
  localparam logic [AW-1:0] ADDR_LAST     = AW'(LED_COUNT - 1);
  localparam logic [15:0]   LED_LIMIT     = 16'(LED_COUNT);

  logic [31:0] store_mem [LED_COUNT];

  lsfb_state_e state_q, state_d;
  logic [AW-1:0] fill_cnt_q, fill_cnt_d;
  logic [31:0]   fill_word_q, fill_word_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [31:0]   rd_q;
  logic [1:0]    lane_q, lane_d;
  logic          in_pix_q, in_pix_d;
  logic          last_q, last_d;

  logic          accept;
  logic [15:0]   idx_ext;
  logic [PW-1:0] offset;
  logic          in_pix;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [31:0]   req_word;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign idx_ext  = 16'(pixel_index_i);
  assign req_word = {FULL_BRIGHT, blue_i, green_i, red_i};

  // The pixel region sits between the start bytes and the end bytes.
  assign offset  = pos_q - POS_PIX_FIRST;
  assign in_pix  = (pos_q >= POS_PIX_FIRST) && (pos_q < POS_PIX_END);
  assign rd_addr = in_pix ? offset[AW+1:2] : '0;

  always_comb begin
    state_d     = state_q;
    fill_cnt_d  = fill_cnt_q;
    fill_word_d = fill_word_q;
    pos_d       = pos_q;
    lane_d      = lane_q;
    in_pix_d    = in_pix_q;
    last_d      = last_q;
    wr_en       = 1'b0;
    wr_addr     = idx_ext[AW-1:0];
    wr_data     = req_word;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_SET: begin
              wr_en = (idx_ext < LED_LIMIT);
            end
            REQ_FILL: begin
              fill_word_d = req_word;
              fill_cnt_d  = '0;
              state_d     = ST_FILL;
            end
            REQ_EMIT: begin
              lane_d   = offset[1:0];
              in_pix_d = in_pix;
              last_d   = (pos_q == POS_LAST);
              pos_d    = (pos_q == POS_LAST) ? '0 : pos_q + PW'(1);
              state_d  = ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_EMIT: begin
        state_d = ST_IDLE;
      end
      ST_FILL: begin
        wr_en      = 1'b1;
        wr_addr    = fill_cnt_q;
        wr_data    = fill_word_q;
        fill_cnt_d = fill_cnt_q + AW'(1);
        if (fill_cnt_q == ADDR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Reset starts a fill sweep with an all-zero word, which clears the store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      fill_cnt_q  <= '0;
      fill_word_q <= '0;
      pos_q       <= '0;
      lane_q      <= LANE_BRIGHT;
      in_pix_q    <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_cnt_q  <= fill_cnt_d;
      fill_word_q <= fill_word_d;
      pos_q       <= pos_d;
      lane_q      <= lane_d;
      in_pix_q    <= in_pix_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= store_mem[rd_addr];
  end

  always_comb begin
    frame_byte_o = '0;
    if (in_pix_q) begin
      case (lane_q)
        LANE_BRIGHT: frame_byte_o = rd_q[31:24];
        LANE_BLUE:   frame_byte_o = rd_q[23:16];
        LANE_GREEN:  frame_byte_o = rd_q[15:8];
        LANE_RED:    frame_byte_o = rd_q[7:0];
        default:     frame_byte_o = '0;
      endcase
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_EMIT);
  assign frame_end_o    = last_q;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for led_strip_frame_builder_core: drives set, fill and emit words
// and checks every frame byte against a local model of the pixel store and frame counter.
// Depends on lsfb_pkg and the core RTL only.
`default_nettype none

module tb_top;
  import lsfb_pkg::*;

  localparam int LED_TOTAL = LED_COUNT_DEF;
  localparam int FRAME_LEN = START_BYTES + 4 * LED_TOTAL +
                             (LED_TOTAL + END_DIVISOR - 1) / END_DIVISOR;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = LED_TOTAL + 16;
  localparam int RANDOM_WORDS = 1600;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic [1:0] req_type;
  logic [5:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       busy;
  logic       result_valid;
  logic [7:0] frame_byte;
  logic       frame_end;

  // Local copy of the strip state, updated as each word is accepted.
  logic [31:0] pixel_mem [LED_TOTAL];
  int          frame_pos;
  frame_word_t frame_q [$];

  int   fail_cnt = 0;
  int   cycle_cnt = 0;
  logic idling_on = 1'b0;

  led_strip_frame_builder_core DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .req_type_i    (req_type),
    .pixel_index_i (pixel_index),
    .red_i         (red),
    .green_i       (green),
    .blue_i        (blue),
    .result_valid_o(result_valid),
    .frame_byte_o  (frame_byte),
    .frame_end_o   (frame_end)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] strip_byte_at(input int pos);
    int off;
    logic [31:0] pix;
    if (pos < START_BYTES) return 8'h00;
    off = pos - START_BYTES;
    if (off >= 4 * LED_TOTAL) return 8'h00;
    pix = pixel_mem[off / 4];
    case (2'(off % 4))
      LANE_BRIGHT: return pix[31:24];
      LANE_BLUE:   return pix[23:16];
      LANE_GREEN:  return pix[15:8];
      default:     return pix[7:0];
    endcase
  endfunction

  function void strip_model_step(input logic [1:0] rt, input logic [5:0] idx,
                                 input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
    frame_word_t w;
    case (rt)
      REQ_SET: begin
        if (idx < LED_TOTAL) pixel_mem[idx] = {FULL_BRIGHT, b, g, r};
      end
      REQ_FILL: begin
        for (int i = 0; i < LED_TOTAL; i++) pixel_mem[i] = {FULL_BRIGHT, b, g, r};
      end
      REQ_EMIT: begin
        if (frame_pos >= FRAME_LEN) frame_pos = 0;
        w.data = strip_byte_at(frame_pos);
        w.last = (frame_pos == FRAME_LEN - 1);
        frame_pos = w.last ? 0 : frame_pos + 1;
        frame_q.push_back(w);
      end
      default: begin
      end
    endcase
  endfunction

  // Holds the word on the ports from the falling edge until a rising edge sees busy low.
  task automatic send_request(input logic [1:0] rt, input logic [5:0] idx,
                              input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
    @(negedge clk);
    start <= 1'b1;
    req_type <= rt;
    pixel_index <= idx;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    strip_model_step(rt, idx, r, g, b);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_idle();
    if (idling_on && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 9));
  endtask

  task automatic send_emit();
    send_request(REQ_EMIT, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_random_set();
    send_request(REQ_SET, 6'($urandom_range(0, 63)), 8'($urandom), 8'($urandom),
                 8'($urandom));
  endtask

  always @(posedge clk) begin : check_result
    frame_word_t want;
    if (rst_n && result_valid) begin
      if (frame_q.size() == 0) begin
        $error("unexpected result: frame_byte=%02h frame_end=%0b", frame_byte, frame_end);
        fail_cnt = fail_cnt + 1;
      end else begin
        want = frame_q.pop_front();
        if (frame_byte !== want.data) begin
          $error("frame_byte: expected %02h, actual %02h", want.data, frame_byte);
          fail_cnt = fail_cnt + 1;
        end
        if (frame_end !== want.last) begin
          $error("frame_end: expected %0b, actual %0b", want.last, frame_end);
          fail_cnt = fail_cnt + 1;
        end
      end
    end
  end

  // Extremes of the fields, the unused request type, writes in the middle of a frame
  // and fills; the frame is walked from its start bytes into the first pixels.
  task automatic test_directed_frame();
    send_request(REQ_SET, 6'd0, 8'hFF, 8'h00, 8'hAA);
    send_request(REQ_SET, 6'd63, 8'h00, 8'hFF, 8'h55);
    send_request(REQ_UNUSED, 6'd5, 8'h12, 8'h34, 8'h56);
    repeat (6) send_emit();
    // Pixel 0 is rewritten after its brightness and blue bytes went out.
    send_request(REQ_SET, 6'd0, 8'h11, 8'h22, 8'h33);
    repeat (2) send_emit();
    send_request(REQ_SET, 6'd1, 8'h00, 8'h00, 8'h00);
    repeat (4) send_emit();
    send_request(REQ_FILL, 6'h3F, 8'h80, 8'h01, 8'hFE);
    repeat (2) send_emit();
    send_request(REQ_FILL, 6'h00, 8'h00, 8'h00, 8'h00);
    send_emit();
  endtask

  // Mostly runs of emits, with sets, the odd fill and some unused words in between.
  task automatic test_random_traffic();
    int sent;
    int pick;
    int run_len;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent % 50 == 0) idling_on = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        run_len = $urandom_range(1, 40);
        repeat (run_len) begin
          send_emit();
          maybe_idle();
        end
        sent += run_len;
      end else if (pick < 92) begin
        send_random_set();
        sent++;
      end else if (pick < 95) begin
        send_request(REQ_FILL, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        sent++;
      end else begin
        send_request(REQ_UNUSED, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
      maybe_idle();
    end
  endtask

  // Full-rate stream of FRAME_LEN + 20 words, mostly emits, with no gaps.
  task automatic test_back_to_back();
    idling_on = 1'b0;
    repeat (FRAME_LEN + 20) begin
      if ($urandom_range(0, 7) == 0) send_random_set();
      else send_emit();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    req_type = REQ_SET;
    pixel_index = '0;
    red = '0;
    green = '0;
    blue = '0;
    frame_pos = 0;
    for (int i = 0; i < LED_TOTAL; i++) pixel_mem[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frame();
    test_random_traffic();
    test_back_to_back();

    @(negedge clk);
    start <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hdl/lsfb_pkg.sv
hdl/led_strip_frame_builder_core.sv
dv/tb_top.sv
